FILE: sv/lnr_pkg.sv
// Shared types and constants for the layer normalization row block.
package lnr_pkg;

    localparam int MAX_ROW_DEF     = 64;
    localparam int SAMPLE_BITS_DEF = 16;

    localparam int DATA_W     = 16;
    localparam int IDX_W      = 6;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;
    localparam int LEN_W      = 7;

    localparam logic [CFG_IDX_W-1:0] CFG_ROW_LENGTH = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_EPSILON    = 1'b1;

    localparam int             ROW_LENGTH_RST = 64;
    localparam logic [15:0]    EPSILON_RST    = 16'd1;
    localparam logic [15:0]    GAMMA_ONE      = 16'd256;

    // shared restoring divider: 49-bit dividend, 34-bit divisor
    localparam int DVD_W     = 49;
    localparam int DSR_W     = 34;
    localparam int DIV_STEPS = DVD_W;
    localparam int SQRT_STEPS = 25;
    localparam int INV_W     = 25;

    typedef enum logic [3:0] {
        S_IDLE,
        S_MDIV,
        S_MEAN,
        S_VAR,
        S_VDIV,
        S_WSET,
        S_RDIV,
        S_SQRT,
        S_ORD,
        S_ODAT,
        S_OM1,
        S_OM2,
        S_OFIN,
        S_OWAIT
    } t_state;

endpackage

FILE: sv/lnr_ifs.sv
// Channel interfaces: input items, result items, configuration writes.
interface lnr_in_if #(parameter int SAMPLE_BITS = lnr_pkg::SAMPLE_BITS_DEF);
    logic                                valid;
    logic                                ready;
    logic                                mode;
    logic [lnr_pkg::IDX_W-1:0]           entry_index;
    logic signed [SAMPLE_BITS-1:0]       sample_value;
    logic signed [lnr_pkg::DATA_W-1:0]   gamma_value;
    logic signed [lnr_pkg::DATA_W-1:0]   beta_value;

    modport source (output valid, mode, entry_index, sample_value, gamma_value, beta_value,
                    input ready);
    modport sink   (input valid, mode, entry_index, sample_value, gamma_value, beta_value,
                    output ready);
endinterface

interface lnr_out_if;
    logic                                valid;
    logic                                ready;
    logic signed [lnr_pkg::DATA_W-1:0]   normalized_value;
    logic                                row_end;
    logic                                clipped;

    modport source (output valid, normalized_value, row_end, clipped, input ready);
    modport sink   (input valid, normalized_value, row_end, clipped, output ready);
endinterface

interface lnr_cfg_if;
    logic                                valid;
    logic                                ready;
    logic [lnr_pkg::CFG_IDX_W-1:0]       index;
    logic [lnr_pkg::CFG_DATA_W-1:0]      data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

FILE: sv/lnr_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
module lnr_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

FILE: sv/layer_normalization_row.sv
// Layer normalization over one row of Q8.8 samples, memory-based sequencer.
//
// Channels: i_in carries items (mode 0 writes a gamma/beta entry, mode 1 a
// sample), o_out carries results, i_cfg writes row_length (index 0) and
// epsilon (index 1). All use valid/ready; a transfer happens when both are high.
// Config is always ready and must only be written while the block is idle.
// A mode-0 item or a sample that does not close a row leaves the block idle.
// The sample that closes a row of n starts the row pass: one shared restoring
// divider run three times (mean, variance, reciprocal), a bitwise square root
// and one row-memory read per sample for the variance. Then each result goes
// through a read/diff/multiply/multiply/round sequence and waits in the output
// register until it transfers, before the next result is started.
// i_in.ready stays low from the row-closing sample until the last result of
// the row has transferred.
// A stalled receiver holds the result in the output register; the sequencer
// waits for the transfer before reading the next position.
// Reset (synchronous, active low) empties the row, restores row_length 64
// and epsilon 1, and marks all gamma/beta entries invalid so they read as
// gamma one and beta zero until written. The row memory needs no clearing.
module layer_normalization_row #(
    parameter int MAX_ROW     = lnr_pkg::MAX_ROW_DEF,
    parameter int SAMPLE_BITS = lnr_pkg::SAMPLE_BITS_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    lnr_in_if.sink    i_in,
    lnr_out_if.source o_out,
    lnr_cfg_if.sink   i_cfg
);
    localparam int AW    = $clog2(MAX_ROW);
    localparam int NW    = $clog2(MAX_ROW + 1);
    localparam int SUM_W = lnr_pkg::DATA_W + AW + 1;
    localparam int NUM_W = SUM_W + 3;
    localparam int SX_W  = (SAMPLE_BITS > lnr_pkg::DATA_W) ? SAMPLE_BITS : lnr_pkg::DATA_W;
    localparam int SQ_W  = 36;
    localparam int SS_W  = SQ_W + AW;
    localparam int DVD_W = lnr_pkg::DVD_W;
    localparam int DSR_W = lnr_pkg::DSR_W;
    localparam int LEN_RST = (lnr_pkg::ROW_LENGTH_RST > MAX_ROW) ? MAX_ROW
                                                                 : lnr_pkg::ROW_LENGTH_RST;

    lnr_pkg::t_state r_state, n_state;

    logic [NW-1:0]          r_len;
    logic [15:0]            r_eps;
    logic [NW-1:0]          r_fill;
    logic signed [SUM_W-1:0] r_sum;
    logic                   r_mean_neg;
    logic signed [16:0]     r_mean;
    logic [NW-1:0]          r_addr;
    logic                   r_rd_v;
    logic                   r_sq_v;
    logic [SQ_W-1:0]        r_sq;
    logic [SS_W-1:0]        r_sumsq;
    logic [DSR_W-1:0]       r_rem;
    logic [DVD_W-1:0]       r_quo;
    logic [DSR_W-1:0]       r_dsr;
    logic [5:0]             r_cnt;
    logic [DVD_W-1:0]       r_sq_q;
    logic [DVD_W-1:0]       r_sq_res;
    logic [DVD_W-1:0]       r_sq_bit;
    logic [lnr_pkg::INV_W-1:0] r_inv;
    logic signed [17:0]     r_diff;
    logic signed [15:0]     r_gam;
    logic signed [15:0]     r_bet;
    logic signed [43:0]     r_p1;
    logic signed [59:0]     r_p2;
    logic [MAX_ROW-1:0]     r_gb_valid;
    logic                   r_gbv_rd;
    logic                   r_out_valid;
    logic signed [15:0]     r_out_value;
    logic                   r_out_end;
    logic                   r_out_clip;

    // handshakes
    logic in_xfer, out_xfer, cfg_xfer;
    assign i_in.ready  = (r_state == lnr_pkg::S_IDLE);
    assign i_cfg.ready = 1'b1;
    assign in_xfer  = i_in.valid && i_in.ready;
    assign out_xfer = o_out.valid && o_out.ready;
    assign cfg_xfer = i_cfg.valid && i_cfg.ready;

    assign o_out.valid            = r_out_valid;
    assign o_out.normalized_value = r_out_value;
    assign o_out.row_end          = r_out_end;
    assign o_out.clipped          = r_out_clip;

    // sample saturation on entry
    logic signed [SX_W-1:0]  s_ext;
    logic signed [15:0]      s_sat;
    always_comb begin
        s_ext = SX_W'(i_in.sample_value);
        if (s_ext > SX_W'(32767)) begin
            s_sat = 16'sh7fff;
        end else if (s_ext < -SX_W'(32768)) begin
            s_sat = 16'sh8000;
        end else begin
            s_sat = s_ext[15:0];
        end
    end

    logic [NW-1:0] fill_inc;
    logic          row_done;
    assign fill_inc = r_fill + NW'(1);
    assign row_done = in_xfer && i_in.mode && (fill_inc == r_len);

    logic signed [SUM_W-1:0] sum_new;
    assign sum_new = r_sum + SUM_W'(s_sat);

    // mean dividend: floor((2*sum + n) / (2n))
    logic signed [NUM_W-1:0] num;
    logic [NUM_W-1:0]        num_mag;
    logic [NW:0]             two_n;
    always_comb begin
        two_n = {r_len, 1'b0};
        num   = (NUM_W'(sum_new) <<< 1) + NUM_W'(signed'({1'b0, r_len}));
        if (num < 0) begin
            num_mag = NUM_W'(-num) + NUM_W'(two_n) - NUM_W'(1);
        end else begin
            num_mag = NUM_W'(num);
        end
    end

    // divider step
    logic [DSR_W:0]   rem_sh;
    logic             div_ge;
    logic [DSR_W-1:0] rem_nx;
    logic             div_last;
    always_comb begin
        rem_sh = {r_rem, r_quo[DVD_W-1]};
        div_ge = (rem_sh >= {1'b0, r_dsr});
        rem_nx = div_ge ? DSR_W'(rem_sh - {1'b0, r_dsr}) : rem_sh[DSR_W-1:0];
    end
    assign div_last = (r_cnt == 6'(lnr_pkg::DIV_STEPS - 1));

    // square root step
    logic [DVD_W:0] sq_try;
    logic           sq_ge;
    assign sq_try = {1'b0, r_sq_res} + {1'b0, r_sq_bit};
    assign sq_ge  = ({1'b0, r_sq_q} >= sq_try);

    // memories
    logic          row_we, gb_we;
    logic [AW-1:0] rd_addr;
    logic [15:0]   row_rdata;
    logic [31:0]   gb_rdata;
    logic          idx_ok;
    assign idx_ok  = (32'(i_in.entry_index) < MAX_ROW);
    assign row_we  = in_xfer && i_in.mode;
    assign gb_we   = in_xfer && !i_in.mode && idx_ok;
    assign rd_addr = r_addr[AW-1:0];

    lnr_ram #(.WIDTH(16), .DEPTH(MAX_ROW)) u_row_ram (
        .i_clk  (i_clk),
        .i_we   (row_we),
        .i_waddr(r_fill[AW-1:0]),
        .i_wdata(s_sat),
        .i_raddr(rd_addr),
        .o_rdata(row_rdata)
    );

    lnr_ram #(.WIDTH(32), .DEPTH(MAX_ROW)) u_gb_ram (
        .i_clk  (i_clk),
        .i_we   (gb_we),
        .i_waddr(i_in.entry_index[AW-1:0]),
        .i_wdata({i_in.gamma_value, i_in.beta_value}),
        .i_raddr(rd_addr),
        .o_rdata(gb_rdata)
    );

    logic signed [17:0] diff_c;
    logic signed [35:0] sq_c;
    assign diff_c = 18'(signed'(row_rdata)) - 18'(r_mean);
    assign sq_c   = 36'(diff_c) * 36'(diff_c);

    logic var_issue;
    assign var_issue = (r_state == lnr_pkg::S_VAR) && (r_addr != r_len);

    // rounding and saturation of the final value
    logic signed [60:0] rnd;
    logic signed [36:0] y_sh;
    logic signed [37:0] y;
    logic signed [15:0] y_sat;
    logic               y_clip;
    always_comb begin
        rnd  = 61'(r_p2) + 61'(64'sd8388608);
        y_sh = 37'(rnd >>> 24);
        y    = 38'(y_sh) + 38'(r_bet);
        if (y > 38'sd32767) begin
            y_sat  = 16'sh7fff;
            y_clip = 1'b1;
        end else if (y < -38'sd32768) begin
            y_sat  = 16'sh8000;
            y_clip = 1'b1;
        end else begin
            y_sat  = y[15:0];
            y_clip = 1'b0;
        end
    end

    logic [DSR_W-1:0] w_sum;
    assign w_sum = DSR_W'(r_quo[32:0]) + DSR_W'(r_eps);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            lnr_pkg::S_IDLE:  if (row_done) n_state = lnr_pkg::S_MDIV;
            lnr_pkg::S_MDIV:  if (div_last) n_state = lnr_pkg::S_MEAN;
            lnr_pkg::S_MEAN:  n_state = lnr_pkg::S_VAR;
            lnr_pkg::S_VAR: begin
                if (!var_issue && !r_rd_v && !r_sq_v) n_state = lnr_pkg::S_VDIV;
            end
            lnr_pkg::S_VDIV:  if (div_last) n_state = lnr_pkg::S_WSET;
            lnr_pkg::S_WSET:  n_state = lnr_pkg::S_RDIV;
            lnr_pkg::S_RDIV:  if (div_last) n_state = lnr_pkg::S_SQRT;
            lnr_pkg::S_SQRT: begin
                if (r_cnt == 6'(lnr_pkg::SQRT_STEPS - 1)) n_state = lnr_pkg::S_ORD;
            end
            lnr_pkg::S_ORD:   n_state = lnr_pkg::S_ODAT;
            lnr_pkg::S_ODAT:  n_state = lnr_pkg::S_OM1;
            lnr_pkg::S_OM1:   n_state = lnr_pkg::S_OM2;
            lnr_pkg::S_OM2:   n_state = lnr_pkg::S_OFIN;
            lnr_pkg::S_OFIN:  n_state = lnr_pkg::S_OWAIT;
            lnr_pkg::S_OWAIT: begin
                if (out_xfer) n_state = r_out_end ? lnr_pkg::S_IDLE : lnr_pkg::S_ORD;
            end
            default:          n_state = lnr_pkg::S_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= lnr_pkg::S_IDLE;
            r_len       <= NW'(LEN_RST);
            r_eps       <= lnr_pkg::EPSILON_RST;
            r_fill      <= '0;
            r_sum       <= '0;
            r_gb_valid  <= '0;
            r_out_valid <= 1'b0;
            r_rd_v      <= 1'b0;
            r_sq_v      <= 1'b0;
        end else begin
            r_state <= n_state;
            r_rd_v  <= var_issue;
            r_sq_v  <= r_rd_v;
            if (cfg_xfer) begin
                case (i_cfg.index)
                    lnr_pkg::CFG_ROW_LENGTH: begin
                        if (i_cfg.data[6:0] < 7'd2) begin
                            r_len <= NW'(2);
                        end else if (32'(i_cfg.data[6:0]) > MAX_ROW) begin
                            r_len <= NW'(MAX_ROW);
                        end else begin
                            r_len <= NW'(i_cfg.data[6:0]);
                        end
                        r_fill <= '0;
                        r_sum  <= '0;
                    end
                    lnr_pkg::CFG_EPSILON: r_eps <= i_cfg.data;
                    default: ;
                endcase
            end
            if (gb_we) begin
                r_gb_valid[i_in.entry_index[AW-1:0]] <= 1'b1;
            end
            if (row_we) begin
                if (row_done) begin
                    r_fill <= '0;
                    r_sum  <= '0;
                end else begin
                    r_fill <= fill_inc;
                    r_sum  <= sum_new;
                end
            end
            if (r_state == lnr_pkg::S_OFIN) begin
                r_out_valid <= 1'b1;
            end else if (out_xfer) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        r_gbv_rd <= r_gb_valid[rd_addr];
        case (r_state)
            lnr_pkg::S_IDLE: begin
                r_mean_neg <= (num < 0);
                r_rem      <= '0;
                r_quo      <= DVD_W'(num_mag);
                r_dsr      <= DSR_W'(two_n);
                r_cnt      <= '0;
            end
            lnr_pkg::S_MDIV, lnr_pkg::S_VDIV: begin
                r_rem <= rem_nx;
                r_quo <= {r_quo[DVD_W-2:0], div_ge};
                r_cnt <= r_cnt + 6'd1;
            end
            lnr_pkg::S_RDIV: begin
                r_rem <= rem_nx;
                r_quo <= {r_quo[DVD_W-2:0], div_ge};
                if (div_last) begin
                    // square-root operands are loaded as the reciprocal division ends
                    r_sq_q   <= {r_quo[DVD_W-2:0], div_ge};
                    r_sq_res <= '0;
                    r_sq_bit <= DVD_W'(1) << 48;
                    r_cnt    <= '0;
                end else begin
                    r_cnt <= r_cnt + 6'd1;
                end
            end
            lnr_pkg::S_MEAN: begin
                r_mean  <= r_mean_neg ? -signed'(r_quo[16:0]) : signed'(r_quo[16:0]);
                r_addr  <= '0;
                r_sumsq <= '0;
            end
            lnr_pkg::S_VAR: begin
                if (var_issue) r_addr <= r_addr + NW'(1);
                if (r_rd_v) r_sq <= SQ_W'(unsigned'(sq_c));
                if (r_sq_v) r_sumsq <= r_sumsq + SS_W'(r_sq);
                r_rem <= '0;
                r_quo <= DVD_W'(r_sumsq + (r_sq_v ? SS_W'(r_sq) : SS_W'(0)));
                r_dsr <= DSR_W'(r_len);
                r_cnt <= '0;
            end
            lnr_pkg::S_WSET: begin
                // reciprocal of variance plus epsilon; zero taken as one
                r_rem <= '0;
                r_quo <= DVD_W'(1) << 48;
                r_dsr <= (w_sum == '0) ? DSR_W'(1) : w_sum;
                r_cnt <= '0;
            end
            lnr_pkg::S_SQRT: begin
                if (sq_ge) begin
                    r_sq_q   <= DVD_W'({1'b0, r_sq_q} - sq_try);
                    r_sq_res <= (r_sq_res >> 1) + r_sq_bit;
                end else begin
                    r_sq_res <= r_sq_res >> 1;
                end
                r_sq_bit <= r_sq_bit >> 2;
                r_cnt    <= r_cnt + 6'd1;
                r_addr   <= '0;
                r_inv    <= lnr_pkg::INV_W'(sq_ge ? (r_sq_res >> 1) + r_sq_bit
                                                  : r_sq_res >> 1);
            end
            lnr_pkg::S_ODAT: begin
                r_diff <= diff_c;
                r_gam  <= r_gbv_rd ? signed'(gb_rdata[31:16]) : signed'(lnr_pkg::GAMMA_ONE);
                r_bet  <= r_gbv_rd ? signed'(gb_rdata[15:0]) : 16'sd0;
            end
            lnr_pkg::S_OM1: r_p1 <= 44'(r_diff) * 44'(signed'({1'b0, r_inv}));
            lnr_pkg::S_OM2: r_p2 <= 60'(r_p1) * 60'(r_gam);
            lnr_pkg::S_OFIN: begin
                r_out_value <= y_sat;
                r_out_clip  <= y_clip;
                r_out_end   <= (r_addr == r_len - NW'(1));
            end
            lnr_pkg::S_OWAIT: begin
                if (out_xfer) r_addr <= r_addr + NW'(1);
            end
            default: ;
        endcase
    end
endmodule

FILE: sv/lnr_checker.sv
// Port-level checks for the layer normalization row block, bound to the top.
module lnr_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_ready,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [15:0] i_out_value,
    input logic        i_cfg_ready
);
    // results of a row are drained before another item is taken
    a_no_in_while_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> !i_in_ready)
        else $error("input ready while a result is pending");

    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid && i_in_ready)
        else $error("block not idle after reset");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_value))
        else $error("stalled result changed");

    a_cfg_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_ready)
        else $error("config port not ready");
endmodule

bind layer_normalization_row lnr_checker u_lnr_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_in_ready (i_in.ready),
    .i_out_valid(o_out.valid),
    .i_out_ready(o_out.ready),
    .i_out_value(o_out.normalized_value),
    .i_cfg_ready(i_cfg.ready)
);

FILE: sim/testbench.sv
// Self-checking testbench for the layer normalization row block.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic signed [15:0] value;
        logic               row_end;
        logic               clipped;
    } t_norm_result;

    logic i_clk;
    logic i_rst_n;

    lnr_in_if  in_if();
    lnr_out_if out_if();
    lnr_cfg_if cfg_if();

    layer_normalization_row i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if),
        .i_cfg   (cfg_if)
    );

    // predictor state
    logic signed [15:0] row_mem [64];
    logic signed [15:0] gamma_mem [64];
    logic signed [15:0] beta_mem [64];
    int                 fill_cnt;
    longint             row_sum;
    logic [6:0]         len_reg;
    logic [15:0]        eps_reg;

    t_norm_result expected_q [$];
    int  mismatch_cnt;
    int  hold_left;
    bit  no_idle;
    longint cycle_cnt;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt > 2000000) begin
            $display("Mismatches found");
            $finish;
        end
    end

    function automatic longint floor_div(longint a, longint b);
        if (a >= 0) return a / b;
        return -((-a + b - 1) / b);
    endfunction

    function automatic longint unsigned root25(longint unsigned q);
        longint unsigned res, bitv;
        res  = 0;
        bitv = 64'd1 << 48;
        for (int k = 0; k < lnr_pkg::SQRT_STEPS; k++) begin
            if (q >= res + bitv) begin
                q   = q - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    task automatic model_sample(logic signed [15:0] s);
        int              n;
        longint          mean, d, y;
        longint unsigned sumsq, w, inv;
        t_norm_result    r;
        n = (len_reg < 2) ? 2 : ((len_reg > 64) ? 64 : len_reg);
        if (fill_cnt >= 64) fill_cnt = 0;
        row_mem[fill_cnt] = s;
        row_sum += s;
        fill_cnt++;
        if (fill_cnt < n) return;
        mean  = floor_div(2 * row_sum + n, 2 * n);
        sumsq = 0;
        for (int k = 0; k < n; k++) begin
            d = longint'(row_mem[k]) - mean;
            sumsq += longint'(d * d);
        end
        w = sumsq / n + eps_reg;
        if (w == 0) w = 1;
        inv = root25((64'd1 << 48) / w);
        for (int k = 0; k < n; k++) begin
            d = longint'(row_mem[k]) - mean;
            y = (d * longint'(inv) * longint'(gamma_mem[k]) + (64'sd1 <<< 23)) >>> 24;
            y += beta_mem[k];
            r.clipped = 1'b0;
            if (y > 32767) begin y = 32767; r.clipped = 1'b1; end
            if (y < -32768) begin y = -32768; r.clipped = 1'b1; end
            r.value   = y[15:0];
            r.row_end = (k == n - 1);
            expected_q.push_back(r);
        end
        fill_cnt = 0;
        row_sum  = 0;
    endtask

    // one input transfer; valid stays high when no gap follows
    task automatic send_item(bit mode, logic [5:0] idx, logic signed [15:0] smp,
                             logic signed [15:0] g, logic signed [15:0] b);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 7);
        if (gap > 0) begin
            in_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_if.valid        <= 1'b1;
        in_if.mode         <= mode;
        in_if.entry_index  <= idx;
        in_if.sample_value <= smp;
        in_if.gamma_value  <= g;
        in_if.beta_value   <= b;
        do @(posedge i_clk); while (!(in_if.valid && in_if.ready));
        if (mode == 1'b0) begin
            gamma_mem[idx] = g;
            beta_mem[idx]  = b;
        end else begin
            model_sample(smp);
        end
    endtask

    task automatic send_sample(logic signed [15:0] smp);
        send_item(1'b1, 6'($urandom), smp, 16'($urandom), 16'($urandom));
    endtask

    task automatic send_entry(logic [5:0] idx, logic signed [15:0] g, logic signed [15:0] b);
        send_item(1'b0, idx, 16'($urandom), g, b);
    endtask

    task automatic wait_idle();
        in_if.valid <= 1'b0;
        while (expected_q.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [lnr_pkg::CFG_IDX_W-1:0] idx, logic [15:0] data);
        wait_idle();
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= data;
        do @(posedge i_clk); while (!(cfg_if.valid && cfg_if.ready));
        cfg_if.valid <= 1'b0;
        if (idx == lnr_pkg::CFG_ROW_LENGTH) begin
            len_reg  = data[6:0];
            fill_cnt = 0;
            row_sum  = 0;
        end else begin
            eps_reg = data;
        end
    endtask

    // result checker and receiver stalls
    int stall_left;
    always @(posedge i_clk) begin
        t_norm_result got, exp_r;
        if (i_rst_n) begin
            if (out_if.valid && out_if.ready) begin
                got.value   = out_if.normalized_value;
                got.row_end = out_if.row_end;
                got.clipped = out_if.clipped;
                if (expected_q.size() == 0) begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= 10)
                        $display("unexpected result: value %0d row_end %0b clipped %0b",
                                 got.value, got.row_end, got.clipped);
                end else begin
                    exp_r = expected_q.pop_front();
                    if (got !== exp_r) begin
                        mismatch_cnt++;
                        if (mismatch_cnt <= 10)
                            $display("result mismatch: expected %0d/%0b/%0b got %0d/%0b/%0b",
                                     exp_r.value, exp_r.row_end, exp_r.clipped,
                                     got.value, got.row_end, got.clipped);
                    end
                end
                stall_left = no_idle ? 0 : $urandom_range(0, 7);
            end
            if (hold_left > 0) begin
                hold_left--;
                out_if.ready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                out_if.ready <= 1'b0;
            end else begin
                out_if.ready <= 1'b1;
            end
        end
    end

    task automatic test_extreme_samples();
        write_reg(lnr_pkg::CFG_ROW_LENGTH, 16'd4);
        send_sample(16'sh7FFF);
        send_sample(-16'sd32768);
        send_sample(16'sd0);
        send_sample(16'sd1);
    endtask

    task automatic test_zero_variance();
        write_reg(lnr_pkg::CFG_EPSILON, 16'd0);
        repeat (4) send_sample(16'sd100);
        write_reg(lnr_pkg::CFG_EPSILON, 16'hFFFF);
        repeat (4) send_sample(-16'sd5);
    endtask

    task automatic test_gamma_beta();
        write_reg(lnr_pkg::CFG_EPSILON, 16'd1);
        send_entry(6'd0, -16'sd32768, 16'sh7FFF);
        send_entry(6'd1, 16'sh7FFF, -16'sd32768);
        send_entry(6'd2, 16'sd0, 16'sd0);
        send_entry(6'd63, 16'sh7FFF, 16'sh7FFF);
        send_sample(16'sd1000);
        send_sample(-16'sd1000);
        send_sample(16'sd300);
        send_sample(-16'sd7);
    endtask

    task automatic test_partial_discard();
        send_sample(16'sd50);
        send_sample(16'sd60);
        write_reg(lnr_pkg::CFG_ROW_LENGTH, 16'hFF83);  // upper bits ignored, length 3
        send_sample(16'sd10);
        send_sample(-16'sd20);
        send_sample(16'sd30);
    endtask

    task automatic test_length_clamp();
        write_reg(lnr_pkg::CFG_ROW_LENGTH, 16'd0);
        send_sample(16'sd256);
        send_sample(-16'sd256);
        write_reg(lnr_pkg::CFG_ROW_LENGTH, 16'd1);
        send_sample(16'sd3);
        send_sample(16'sd4);
    endtask

    task automatic test_backpressure();
        write_reg(lnr_pkg::CFG_ROW_LENGTH, 16'd4);
        hold_left = 600;
        no_idle   = 1'b1;
        repeat (12) send_sample(16'($urandom));
        no_idle   = 1'b0;
    endtask

    task automatic test_random_rows();
        int sent, n, pick;
        sent = 0;
        while (sent < 90) begin
            pick = $urandom_range(0, 9);
            if (pick == 0)      n = 127;
            else if (pick == 1) n = 64;
            else                n = $urandom_range(2, 8);
            write_reg(lnr_pkg::CFG_ROW_LENGTH, {9'($urandom_range(0, 511)), n[6:0]});
            pick = $urandom_range(0, 3);
            write_reg(lnr_pkg::CFG_EPSILON,
                      pick == 0 ? 16'd0 : (pick == 1 ? 16'hFFFF : 16'($urandom)));
            no_idle = ($urandom_range(0, 3) == 0);
            repeat ($urandom_range(0, 4)) begin
                send_entry(6'($urandom_range(0, 7)), 16'($urandom), 16'($urandom));
                sent++;
            end
            if (n > 64) n = 64;
            repeat ($urandom_range(1, n > 8 ? 1 : 3) * n) begin
                if ($urandom_range(0, 1)) send_sample(16'($urandom));
                else send_sample($signed(16'($urandom_range(0, 1023))) - 16'sd512);
                sent++;
            end
            // occasional trailing partial row, dropped by the next length write
            if ($urandom_range(0, 4) == 0) begin
                send_sample(16'($urandom));
                sent++;
            end
        end
        no_idle = 1'b0;
    endtask

    initial begin
        i_clk = 1'b0;
        i_rst_n = 1'b0;
        in_if.valid = 1'b0;
        in_if.mode = 1'b0;
        in_if.entry_index = '0;
        in_if.sample_value = '0;
        in_if.gamma_value = '0;
        in_if.beta_value = '0;
        out_if.ready = 1'b0;
        cfg_if.valid = 1'b0;
        cfg_if.index = lnr_pkg::CFG_ROW_LENGTH;
        cfg_if.data = '0;
        mismatch_cnt = 0;
        hold_left = 0;
        stall_left = 0;
        no_idle = 1'b0;
        cycle_cnt = 0;
        for (int k = 0; k < 64; k++) begin
            row_mem[k]   = '0;
            gamma_mem[k] = lnr_pkg::GAMMA_ONE;
            beta_mem[k]  = '0;
        end
        fill_cnt = 0;
        row_sum  = 0;
        len_reg  = 7'(lnr_pkg::ROW_LENGTH_RST);
        eps_reg  = lnr_pkg::EPSILON_RST;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_extreme_samples();
        test_zero_variance();
        test_gamma_beta();
        test_partial_discard();
        test_length_clamp();
        test_backpressure();
        test_random_rows();

        wait_idle();
        repeat (300) @(posedge i_clk);
        if (mismatch_cnt == 0 && expected_q.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
